// ----- rtl/spc_pkg.sv -----
// Package for the steering PID/PWM controller.
// Transaction structs, command/status structs, register indexes, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
package spc_pkg;

   typedef struct packed {
      logic [7:0]         command;
      logic               link_ok;
      logic [9:0]         pot_reading;
      logic signed [15:0] stick_value;
      logic signed [15:0] auto_target;
      logic               auto_valid;
      logic [15:0]        elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [7:0]         drive_right;
      logic [7:0]         drive_left;
      logic [3:0]         action;
      logic signed [15:0] error_value;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic pid;
      logic div_busy;
   } stat_type;

   // datapath operations
   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_LOAD    = 4'd1;
   localparam logic [3:0] OP_MAP     = 4'd2;
   localparam logic [3:0] OP_ERR     = 4'd3;
   localparam logic [3:0] OP_MUL_ED  = 4'd4;
   localparam logic [3:0] OP_DIV_INC = 4'd5;
   localparam logic [3:0] OP_INTEG   = 4'd6;
   localparam logic [3:0] OP_MUL_GD  = 4'd7;
   localparam logic [3:0] OP_MUL_K   = 4'd8;
   localparam logic [3:0] OP_DIV_D   = 4'd9;
   localparam logic [3:0] OP_MUL_P   = 4'd10;
   localparam logic [3:0] OP_MUL_I   = 4'd11;
   localparam logic [3:0] OP_SUM     = 4'd12;
   localparam logic [3:0] OP_FINISH  = 4'd13;

   // register indexes
   localparam logic [2:0] REG_GAIN_P      = 3'd0;
   localparam logic [2:0] REG_GAIN_I      = 3'd1;
   localparam logic [2:0] REG_GAIN_D      = 3'd2;
   localparam logic [2:0] REG_POT_RIGHT   = 3'd3;
   localparam logic [2:0] REG_POT_CENTER  = 3'd4;
   localparam logic [2:0] REG_POT_LEFT    = 3'd5;
   localparam logic [2:0] REG_PWM_FLOOR   = 3'd6;
   localparam logic [2:0] REG_PWM_CEILING = 3'd7;

   // command modes
   localparam logic [7:0] CMD_PAUSE  = 8'd0;
   localparam logic [7:0] CMD_MANUAL = 8'd1;
   localparam logic [7:0] CMD_AUTO   = 8'd2;

   // action codes
   localparam logic [3:0] ACT_NOSIGNAL = 4'd0;
   localparam logic [3:0] ACT_PAUSE    = 4'd1;
   localparam logic [3:0] ACT_MAN_N    = 4'd2;
   localparam logic [3:0] ACT_MAN_L    = 4'd3;
   localparam logic [3:0] ACT_MAN_R    = 4'd4;
   localparam logic [3:0] ACT_AUTO_N   = 4'd5;
   localparam logic [3:0] ACT_AUTO_R   = 4'd6;
   localparam logic [3:0] ACT_AUTO_L   = 4'd7;
   localparam logic [3:0] ACT_HOLD     = 4'd8;
   localparam logic [3:0] ACT_OTHER    = 4'd9;

   // reset values
   localparam logic [15:0] RST_GAIN_P      = 16'd4096;
   localparam logic [15:0] RST_GAIN_I      = 16'd82;
   localparam logic [15:0] RST_GAIN_D      = 16'd328;
   localparam logic [9:0]  RST_POT_RIGHT   = 10'd197;
   localparam logic [9:0]  RST_POT_CENTER  = 10'd447;
   localparam logic [9:0]  RST_POT_LEFT    = 10'd815;
   localparam logic [7:0]  RST_PWM_FLOOR   = 8'd150;
   localparam logic [7:0]  RST_PWM_CEILING = 8'd235;

   localparam int          INT_CLAMP    = 102400;
   localparam logic [15:0] DEADBAND_Q4  = 16'd160;
   localparam logic [10:0] STICK_CENTER = 11'd512;
   localparam logic [10:0] STICK_MAX    = 11'd1024;
   localparam logic [15:0] INC_DIVISOR  = 16'd125;
   localparam logic [16:0] D_SCALE      = 17'd64000;

   localparam int QUO_W     = 48;
   localparam int DIV_STEPS = QUO_W / 2;

endpackage

// ----- rtl/steering_pid_pwm_controller.sv -----
// Steering PID/PWM controller: one result transaction per accepted control tick.
// A pause, hold, no-link or unknown-mode tick goes from decode straight to the result register;
// a manual or auto PID tick steps through the map, error, integral and derivative operations,
// using the shared two-bit-per-cycle divider twice (integral increment by 125, derivative
// by elapsed time) and the single shared multiplier for each multiply. A new tick is accepted
// as soon as the previous one reaches the result register, even if that result is still
// waiting to be taken. Depends on spc_pkg, spc_ctrl and spc_datapath.
`timescale 1ns / 1ps
module steering_pid_pwm_controller
   import spc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   spc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spc_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

// ----- rtl/spc_div.sv -----
// Unsigned restoring divider, 48-bit dividend by 16-bit divisor, two bits per cycle.
// Depends on spc_pkg.
`timescale 1ns / 1ps
module spc_div
   import spc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [QUO_W-1:0]  dividend,
   input  logic [15:0]       divisor,
   output logic              busy,
   output logic [QUO_W-1:0]  quotient
);

   logic [15:0]      rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [15:0]      dsr_ff, dsr_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [16:0]      s1, s2;

   function automatic logic [16:0] div_step(input logic [15:0] rem, input logic bit_in,
                                             input logic [15:0] d);
      logic [16:0] t;
      t = {rem, bit_in};
      if (t >= {1'b0, d}) begin
         div_step = {1'b1, 16'(t - {1'b0, d})};
      end else begin
         div_step = {1'b0, t[15:0]};
      end
   endfunction

   always_comb begin
      s1      = div_step(rem_ff, quo_ff[QUO_W-1], dsr_ff);
      s2      = div_step(s1[15:0], quo_ff[QUO_W-2], dsr_ff);
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = 5'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = s2[15:0];
         quo_in  = {quo_ff[QUO_W-3:0], s1[16], s2[16]};
         cnt_in  = cnt_ff - 5'd1;
         busy_in = (cnt_ff != 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/spc_datapath.sv -----
// Datapath: configuration registers, shared multiplier, divider, PID state and result register.
// Depends on spc_pkg and spc_div.
`timescale 1ns / 1ps
module spc_datapath
   import spc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  req_type     req_data,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [9:0]  pot_right_ff, pot_center_ff, pot_left_ff;
   logic [7:0]  pwm_floor_ff, pwm_ceiling_ff;

   req_type            in_ff;
   rsp_type            rsp_ff, rsp_in;
   logic signed [50:0] prod_ff;
   logic signed [15:0] err_ff, err_in;
   logic signed [16:0] de_ff;
   logic signed [15:0] prev_ff;
   logic signed [17:0] integ_ff, integ_in;
   logic signed [51:0] acc_ff, acc_in;
   logic               sign_ff;

   logic signed [33:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [50:0] mul_p;
   logic [10:0]        s_clamp, s_seg;
   logic               seg_hi, manual, pid, dt_zero;
   logic signed [10:0] slope;
   logic [50:0]        pmag;
   logic [QUO_W-1:0]   div_dividend, quo;
   logic [15:0]        div_divisor;
   logic               div_start, div_busy;
   logic signed [17:0] sp, diff;
   logic signed [29:0] inc, isum;
   logic signed [51:0] dterm, amag;
   logic [29:0]        lvl_m;
   logic [7:0]         lvl;
   logic               pos, in_db;

   spc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= RST_GAIN_P;
         gain_i_ff      <= RST_GAIN_I;
         gain_d_ff      <= RST_GAIN_D;
         pot_right_ff   <= RST_POT_RIGHT;
         pot_center_ff  <= RST_POT_CENTER;
         pot_left_ff    <= RST_POT_LEFT;
         pwm_floor_ff   <= RST_PWM_FLOOR;
         pwm_ceiling_ff <= RST_PWM_CEILING;
      end else if (csr_we) begin
         case (csr_index)
            REG_GAIN_P:      gain_p_ff      <= csr_wdata;
            REG_GAIN_I:      gain_i_ff      <= csr_wdata;
            REG_GAIN_D:      gain_d_ff      <= csr_wdata;
            REG_POT_RIGHT:   pot_right_ff   <= csr_wdata[9:0];
            REG_POT_CENTER:  pot_center_ff  <= csr_wdata[9:0];
            REG_POT_LEFT:    pot_left_ff    <= csr_wdata[9:0];
            REG_PWM_FLOOR:   pwm_floor_ff   <= csr_wdata[7:0];
            REG_PWM_CEILING: pwm_ceiling_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      manual  = (in_ff.command == CMD_MANUAL);
      pid     = in_ff.link_ok && (manual || (in_ff.command == CMD_AUTO && in_ff.auto_valid));
      dt_zero = (in_ff.elapsed_ms == 16'd0);

      if (in_ff.stick_value < 0) begin
         s_clamp = '0;
      end else if (in_ff.stick_value > $signed({5'd0, STICK_MAX})) begin
         s_clamp = STICK_MAX;
      end else begin
         s_clamp = in_ff.stick_value[10:0];
      end
      seg_hi = (s_clamp > STICK_CENTER);
      s_seg  = seg_hi ? (s_clamp - STICK_CENTER) : s_clamp;
      slope  = seg_hi ? ($signed({1'b0, pot_left_ff}) - $signed({1'b0, pot_center_ff}))
                      : ($signed({1'b0, pot_center_ff}) - $signed({1'b0, pot_right_ff}));

      case (cmd.op)
         OP_MAP: begin
            mul_a = $signed({23'd0, s_seg});
            mul_b = 17'(slope);
         end
         OP_MUL_ED: begin
            mul_a = 34'(err_ff);
            mul_b = $signed({1'b0, in_ff.elapsed_ms});
         end
         OP_MUL_GD: begin
            mul_a = 34'(de_ff);
            mul_b = $signed({1'b0, gain_d_ff});
         end
         OP_MUL_K: begin
            mul_a = prod_ff[33:0];
            mul_b = $signed(D_SCALE);
         end
         OP_MUL_P: begin
            mul_a = 34'(err_ff);
            mul_b = $signed({1'b0, gain_p_ff});
         end
         OP_MUL_I: begin
            mul_a = 34'(integ_ff);
            mul_b = $signed({1'b0, gain_i_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;

      pmag         = prod_ff[50] ? 51'(-prod_ff) : 51'(prod_ff);
      div_start    = (cmd.op == OP_DIV_INC) || (cmd.op == OP_DIV_D);
      div_dividend = (cmd.op == OP_DIV_INC) ? {pmag[44:0], 3'b000} : pmag[47:0];
      div_divisor  = (cmd.op == OP_DIV_INC) ? INC_DIVISOR : in_ff.elapsed_ms;

      // setpoint and saturated error
      if (manual) begin
         sp = $signed({4'd0, (seg_hi ? pot_center_ff : pot_right_ff), 4'd0})
            + 18'($signed(prod_ff[20:5]));
      end else begin
         sp = 18'(in_ff.auto_target);
      end
      diff = sp - $signed({4'd0, in_ff.pot_reading, 4'd0});
      if (diff > 18'sd32767) begin
         err_in = 16'sh7FFF;
      end else if (diff < -18'sd32768) begin
         err_in = 16'sh8000;
      end else begin
         err_in = diff[15:0];
      end

      // integrator with clamp
      inc  = sign_ff ? -$signed({1'b0, quo[28:0]}) : $signed({1'b0, quo[28:0]});
      isum = 30'(integ_ff) + inc;
      if (isum > 30'(INT_CLAMP)) begin
         integ_in = 18'(INT_CLAMP);
      end else if (isum < -30'(INT_CLAMP)) begin
         integ_in = -18'(INT_CLAMP);
      end else begin
         integ_in = isum[17:0];
      end

      dterm = sign_ff ? -$signed({4'd0, quo}) : $signed({4'd0, quo});

      case (cmd.op)
         OP_MUL_P: acc_in = dt_zero ? '0 : dterm;
         OP_MUL_I: acc_in = acc_ff + (52'(prod_ff) <<< 6);
         OP_SUM:   acc_in = acc_ff + 52'(prod_ff);
         default:  acc_in = acc_ff;
      endcase

      // drive level and action
      amag  = acc_ff[51] ? -acc_ff : acc_ff;
      lvl_m = amag[51:22];
      if (lvl_m < {22'd0, pwm_floor_ff}) begin
         lvl = pwm_floor_ff;
      end else if (lvl_m > {22'd0, pwm_ceiling_ff}) begin
         lvl = pwm_ceiling_ff;
      end else begin
         lvl = lvl_m[7:0];
      end
      pos   = !acc_ff[51] && (acc_ff != '0);
      in_db = (err_ff <= $signed(DEADBAND_Q4)) && (err_ff >= -$signed(DEADBAND_Q4));

      rsp_in             = '0;
      rsp_in.error_value = pid ? err_ff : 16'sd0;
      if (!in_ff.link_ok) begin
         rsp_in.action = ACT_NOSIGNAL;
      end else if (in_ff.command == CMD_PAUSE) begin
         rsp_in.action = ACT_PAUSE;
      end else if (in_ff.command == CMD_AUTO && !in_ff.auto_valid) begin
         rsp_in.action = ACT_HOLD;
      end else if (!pid) begin
         rsp_in.action = ACT_OTHER;
      end else if (in_db) begin
         rsp_in.action = manual ? ACT_MAN_N : ACT_AUTO_N;
      end else if (manual) begin
         if (pos) begin
            rsp_in.drive_left = lvl;
            rsp_in.action     = ACT_MAN_L;
         end else begin
            rsp_in.drive_right = lvl;
            rsp_in.action      = ACT_MAN_R;
         end
      end else begin
         if (pos) begin
            rsp_in.drive_right = lvl;
            rsp_in.action      = ACT_AUTO_R;
         end else begin
            rsp_in.drive_left = lvl;
            rsp_in.action     = ACT_AUTO_L;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         prev_ff  <= '0;
      end else if (cmd.op == OP_INTEG) begin
         integ_ff <= integ_in;
         prev_ff  <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         in_ff <= req_data;
      end
      if (cmd.op == OP_MAP || cmd.op == OP_MUL_ED || cmd.op == OP_MUL_GD ||
          cmd.op == OP_MUL_K || cmd.op == OP_MUL_P || cmd.op == OP_MUL_I) begin
         prod_ff <= mul_p;
      end
      if (cmd.op == OP_ERR) begin
         err_ff <= err_in;
      end
      if (cmd.op == OP_INTEG) begin
         de_ff <= 17'(err_ff) - 17'(prev_ff);
      end
      if (div_start) begin
         sign_ff <= prod_ff[50];
      end
      acc_ff <= acc_in;
      if (cmd.op == OP_FINISH) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.pid      = pid;
   assign stat.div_busy = div_busy;
   assign rsp_data      = rsp_ff;

endmodule

// ----- rtl/spc_ctrl.sv -----
// Controller state machine: sequences datapath operations and owns both handshakes.
// Depends on spc_pkg.
`timescale 1ns / 1ps
module spc_ctrl
   import spc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DECODE   = 4'd1;
   localparam logic [3:0] ST_MAP      = 4'd2;
   localparam logic [3:0] ST_ERR      = 4'd3;
   localparam logic [3:0] ST_MUL_ED   = 4'd4;
   localparam logic [3:0] ST_DIV_INC  = 4'd5;
   localparam logic [3:0] ST_WAIT_INC = 4'd6;
   localparam logic [3:0] ST_INTEG    = 4'd7;
   localparam logic [3:0] ST_MUL_GD   = 4'd8;
   localparam logic [3:0] ST_MUL_K    = 4'd9;
   localparam logic [3:0] ST_DIV_D    = 4'd10;
   localparam logic [3:0] ST_WAIT_D   = 4'd11;
   localparam logic [3:0] ST_MUL_P    = 4'd12;
   localparam logic [3:0] ST_MUL_I    = 4'd13;
   localparam logic [3:0] ST_SUM      = 4'd14;
   localparam logic [3:0] ST_FINISH   = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       fire;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      fire     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE:  state_in = stat.pid ? ST_MAP : ST_FINISH;
         ST_MAP: begin
            cmd.op   = OP_MAP;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.op   = OP_ERR;
            state_in = ST_MUL_ED;
         end
         ST_MUL_ED: begin
            cmd.op   = OP_MUL_ED;
            state_in = ST_DIV_INC;
         end
         ST_DIV_INC: begin
            cmd.op   = OP_DIV_INC;
            state_in = ST_WAIT_INC;
         end
         ST_WAIT_INC: if (!stat.div_busy) state_in = ST_INTEG;
         ST_INTEG: begin
            cmd.op   = OP_INTEG;
            state_in = ST_MUL_GD;
         end
         ST_MUL_GD: begin
            cmd.op   = OP_MUL_GD;
            state_in = ST_MUL_K;
         end
         ST_MUL_K: begin
            cmd.op   = OP_MUL_K;
            state_in = ST_DIV_D;
         end
         ST_DIV_D: begin
            cmd.op   = OP_DIV_D;
            state_in = ST_WAIT_D;
         end
         ST_WAIT_D: if (!stat.div_busy) state_in = ST_MUL_P;
         ST_MUL_P: begin
            cmd.op   = OP_MUL_P;
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.op   = OP_MUL_I;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = OP_FINISH;
               fire     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECODE))
      else $error("accepted transaction did not advance to decode");

   a_div_started: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_INC || state_ff == ST_DIV_D) |=> stat.div_busy)
      else $error("divider not busy after start");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready) |=>
      (state_ff == ST_FINISH && rsp_valid_ff))
      else $error("result overwritten while output stalled");
`endif

endmodule

// ----- verif/testbench.sv -----
// Testbench for steering_pid_pwm_controller: directed and random control ticks
// checked field by field against an in-bench PID/PWM predictor.
// Depends on spc_pkg and the controller RTL.
`timescale 1ns / 1ps
module testbench;
   import spc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   steering_pid_pwm_controller u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // predictor copy of registers and state
   longint kp, ki, kd, p_right, p_center, p_left, lvl_min, lvl_max;
   longint sp_q4, integ_acc, err_prev;
   rsp_type expected_q[$];
   int  mismatches = 0;
   int  sent = 0;
   int  checked = 0;
   int  wait_cnt = 0;
   longint cycles = 0;
   bit  no_idle = 1'b0;

   function automatic longint floor32(longint n);
      longint q;
      q = n / 32;
      if ((n % 32) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic rsp_type predict_tick(req_type t);
      rsp_type r;
      longint rd, s, e, inc, dterm, sum, mag, lvl;
      bit manual;
      r = '0;
      rd = longint'(t.pot_reading) * 16;
      if (!t.link_ok) begin
         r.action = ACT_NOSIGNAL;
      end else if (t.command == CMD_PAUSE) begin
         sp_q4 = rd;
         r.action = ACT_PAUSE;
      end else if (t.command == CMD_AUTO && !t.auto_valid) begin
         sp_q4 = rd;
         r.action = ACT_HOLD;
      end else if (t.command == CMD_MANUAL || t.command == CMD_AUTO) begin
         manual = (t.command == CMD_MANUAL);
         if (manual) begin
            s = longint'(t.stick_value);
            if (s < 0) s = 0;
            if (s > 1024) s = 1024;
            if (s <= 512) sp_q4 = p_right * 16 + floor32(s * (p_center - p_right));
            else sp_q4 = p_center * 16 + floor32((s - 512) * (p_left - p_center));
            sp_q4 = longint'(int'(sp_q4));
         end else begin
            sp_q4 = longint'(t.auto_target);
         end
         e = sp_q4 - rd;
         if (e > 32767) e = 32767;
         if (e < -32768) e = -32768;
         r.error_value = e[15:0];
         inc = (e * longint'(t.elapsed_ms) * 8) / 125;
         integ_acc = integ_acc + inc;
         if (integ_acc > INT_CLAMP) integ_acc = INT_CLAMP;
         if (integ_acc < -INT_CLAMP) integ_acc = -INT_CLAMP;
         dterm = 0;
         if (t.elapsed_ms != 0)
            dterm = (kd * (e - err_prev) * 64000) / longint'(t.elapsed_ms);
         err_prev = e;
         sum = kp * e * 64 + ki * integ_acc + dterm;
         if (e <= 160 && e >= -160) begin
            r.action = manual ? ACT_MAN_N : ACT_AUTO_N;
         end else begin
            mag = (sum < 0 ? -sum : sum) >>> 22;
            if (mag < lvl_min) lvl = lvl_min;
            else if (mag > lvl_max) lvl = lvl_max;
            else lvl = mag;
            if (manual) begin
               if (sum > 0) begin r.drive_left = lvl[7:0]; r.action = ACT_MAN_L; end
               else begin r.drive_right = lvl[7:0]; r.action = ACT_MAN_R; end
            end else begin
               if (sum > 0) begin r.drive_right = lvl[7:0]; r.action = ACT_AUTO_R; end
               else begin r.drive_left = lvl[7:0]; r.action = ACT_AUTO_L; end
            end
         end
      end else begin
         r.action = ACT_OTHER;
      end
      return r;
   endfunction

   // valid stays high into a back-to-back transaction; it drops only before an idle gap
   task automatic send_tick(req_type t);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_q.push_back(predict_tick(t));
      sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // write enable is dropped by the next random run
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_GAIN_P:      kp = longint'(val);
         REG_GAIN_I:      ki = longint'(val);
         REG_GAIN_D:      kd = longint'(val);
         REG_POT_RIGHT:   p_right = longint'(val[9:0]);
         REG_POT_CENTER:  p_center = longint'(val[9:0]);
         REG_POT_LEFT:    p_left = longint'(val[9:0]);
         REG_PWM_FLOOR:   lvl_min = longint'(val[7:0]);
         REG_PWM_CEILING: lvl_max = longint'(val[7:0]);
         default: ;
      endcase
   endtask

   function automatic req_type rand_tick(bit pid_bias);
      req_type t;
      int k;
      t = '0;
      k = $urandom_range(0, 19);
      if (pid_bias && k < 16) t.command = (k < 8) ? CMD_MANUAL : CMD_AUTO;
      else if (k < 18) t.command = CMD_PAUSE;
      else t.command = 8'($urandom_range(0, 255));
      t.link_ok = ($urandom_range(0, 15) != 0);
      t.pot_reading = 10'($urandom_range(0, 1023));
      t.stick_value = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 1100));
      case ($urandom_range(0, 3))
         0:       t.auto_target = 16'($urandom);
         1:       t.auto_target = 16'(t.pot_reading * 16 + $urandom_range(0, 400) - 200);
         default: t.auto_target = 16'($urandom_range(0, 16383));
      endcase
      t.auto_valid = ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 5))
         0:       t.elapsed_ms = 16'd0;
         1:       t.elapsed_ms = 16'($urandom);
         default: t.elapsed_ms = 16'($urandom_range(1, 200));
      endcase
      return t;
   endfunction

   function automatic req_type make_tick(logic [7:0] c, logic l, logic [9:0] p,
                                         logic [15:0] s, logic [15:0] a, logic v,
                                         logic [15:0] ms);
      req_type t;
      t.command = c; t.link_ok = l; t.pot_reading = p; t.stick_value = s;
      t.auto_target = a; t.auto_valid = v; t.elapsed_ms = ms;
      return t;
   endfunction

   task automatic test_modes;
      send_tick(make_tick(CMD_MANUAL, 1'b0, 10'd500, 16'd900, 16'd0, 1'b1, 16'd100));
      send_tick(make_tick(8'd3, 1'b1, 10'd500, 16'd900, 16'd0, 1'b1, 16'd100));
      send_tick(make_tick(8'd255, 1'b1, 10'd1023, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF));
      send_tick(make_tick(CMD_PAUSE, 1'b1, 10'd0, 16'd0, 16'd0, 1'b0, 16'd0));
      send_tick(make_tick(CMD_AUTO, 1'b1, 10'd300, 16'd0, 16'd9000, 1'b0, 16'd50));
      send_tick(make_tick(CMD_AUTO, 1'b1, 10'd300, 16'd0, 16'd9000, 1'b1, 16'd50));
      send_tick(make_tick(CMD_AUTO, 1'b1, 10'd300, 16'd0, 16'd1000, 1'b1, 16'd50));
      send_tick(make_tick(CMD_AUTO, 1'b1, 10'd300, 16'd0, 16'd4960, 1'b1, 16'd0));
      send_tick(make_tick(CMD_AUTO, 1'b1, 10'd300, 16'd0, 16'd4640, 1'b1, 16'd10));
      send_tick(make_tick(CMD_AUTO, 1'b1, 10'd300, 16'd0, 16'd4639, 1'b1, 16'd10));
      send_tick(make_tick(CMD_AUTO, 1'b1, 10'd0, 16'd0, 16'h7FFF, 1'b1, 16'hFFFF));
      send_tick(make_tick(CMD_AUTO, 1'b1, 10'd1023, 16'd0, 16'h8000, 1'b1, 16'd1));
      send_tick(make_tick(CMD_MANUAL, 1'b1, 10'd447, 16'h8000, 16'd0, 1'b1, 16'd100));
      send_tick(make_tick(CMD_MANUAL, 1'b1, 10'd447, 16'd512, 16'd0, 1'b1, 16'd100));
      send_tick(make_tick(CMD_MANUAL, 1'b1, 10'd447, 16'd513, 16'd0, 1'b1, 16'd100));
      send_tick(make_tick(CMD_MANUAL, 1'b1, 10'd100, 16'd1024, 16'd0, 1'b1, 16'd0));
      send_tick(make_tick(CMD_MANUAL, 1'b1, 10'd900, 16'h7FFF, 16'd0, 1'b1, 16'd7));
      for (int i = 0; i < 6; i++)
         send_tick(make_tick(CMD_AUTO, 1'b1, 10'd0, 16'd0, 16'h7FFF, 1'b1, 16'd60000));
      drain();
   endtask

   task automatic test_random_run(int n);
      csr_we <= 1'b0;
      for (int i = 0; i < n; i++) begin
         no_idle = ((i / 40) % 3 == 2);
         send_tick(rand_tick(1'b1));
      end
      no_idle = 1'b0;
      drain();
   endtask

   task automatic test_register_sets;
      write_reg(REG_GAIN_P, 16'hFFFF);
      write_reg(REG_GAIN_I, 16'hFFFF);
      write_reg(REG_GAIN_D, 16'hFFFF);
      write_reg(REG_POT_RIGHT, 16'd1023);
      write_reg(REG_POT_CENTER, 16'd0);
      write_reg(REG_POT_LEFT, 16'd1023);
      write_reg(REG_PWM_FLOOR, 16'd255);
      write_reg(REG_PWM_CEILING, 16'd0);
      test_random_run(90);
      write_reg(REG_GAIN_P, 16'd0);
      write_reg(REG_GAIN_I, 16'd0);
      write_reg(REG_GAIN_D, 16'd0);
      write_reg(REG_POT_RIGHT, 16'd0);
      write_reg(REG_POT_CENTER, 16'd512);
      write_reg(REG_POT_LEFT, 16'd0);
      write_reg(REG_PWM_FLOOR, 16'd0);
      write_reg(REG_PWM_CEILING, 16'd255);
      test_random_run(60);
      for (int k = 0; k < 3; k++) begin
         for (int r = 0; r < 8; r++) write_reg(r[2:0], 16'($urandom));
         test_random_run(50);
      end
   endtask

   // result checker; the receiver may stall ready at random after each accepted transaction, except in no-idle runs
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction %h", rsp_data);
            end else begin
               exp_r = expected_q.pop_front();
               checked++;
               if (rsp_data.drive_right !== exp_r.drive_right ||
                   rsp_data.drive_left !== exp_r.drive_left ||
                   rsp_data.action !== exp_r.action ||
                   rsp_data.error_value !== exp_r.error_value) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp R=%0d L=%0d act=%0d err=%0d got R=%0d L=%0d act=%0d err=%0d",
                        exp_r.drive_right, exp_r.drive_left, exp_r.action, exp_r.error_value,
                        rsp_data.drive_right, rsp_data.drive_left, rsp_data.action,
                        rsp_data.error_value);
               end
            end
            wait_cnt = no_idle ? 0 : $urandom_range(0, 5);
            rsp_ready <= (wait_cnt == 0);
         end else if (!rsp_ready) begin
            if (wait_cnt > 0) wait_cnt--;
            if (wait_cnt == 0) rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      kp = RST_GAIN_P; ki = RST_GAIN_I; kd = RST_GAIN_D;
      p_right = RST_POT_RIGHT; p_center = RST_POT_CENTER; p_left = RST_POT_LEFT;
      lvl_min = RST_PWM_FLOOR; lvl_max = RST_PWM_CEILING;
      sp_q4 = 447 * 16; integ_acc = 0; err_prev = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_modes();
      test_random_run(225);
      test_register_sets();
      $display("Covered %0d ticks, %0d results checked, all modes and register extremes.",
         sent, checked);
      if (mismatches == 0 && expected_q.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
